@@ hw/rtl/radial_flow_key_shader_core_assert.svh @@
// Assertion macros for the radial flow key shader.
`ifndef RADIAL_FLOW_KEY_SHADER_CORE_ASSERT_SVH
`define RADIAL_FLOW_KEY_SHADER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RFKS_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define RFKS_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RFKS_ASSERT_IMPL(label, clk, rst_n, prop)
`define RFKS_ASSERT_NORST(label, clk, prop)
`endif
`endif

@@ hw/rtl/rfks_pkg.sv @@
package rfks_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned NumRegs = 5;
  localparam logic [2:0] RegFlowSpeed = 3'd0;
  localparam logic [2:0] RegAxisScales = 3'd1;
  localparam logic [2:0] RegCentreMethod = 3'd2;
  localparam logic [2:0] RegColourScales = 3'd3;
  localparam logic [2:0] RegRingShape = 3'd4;
  localparam logic [1:0] MethodManhattan = 2'd0;
  localparam logic [1:0] MethodMaximum = 2'd1;
  localparam logic [1:0] MethodRoot = 2'd2;

  // Start/busy pair between the sequencer and a serial unit.
  typedef struct packed {
    logic start;
    logic busy;
  } unit_ctl_t;
endpackage

@@ hw/rtl/radial_flow_key_shader_core.sv @@
// Words are shaded one at a time. The root method adds two squarings and up to ROOT_ROUNDS
// Newton rounds of one divide each, and a ring fade adds a multiply and a divide.
// The next word is accepted in the cycle after the result is loaded into the output register.
// Each product is formed on the shared bit-serial multiplier and each quotient on the
// shared bit-serial divider.
// Reset (synchronous, rst_n low) clears the configuration registers, the sequencer and out_valid.
`include "radial_flow_key_shader_core_assert.svh"
module radial_flow_key_shader_core #(
  parameter int unsigned ROOT_ROUNDS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_time_stamp,
  input  logic [15:0] in_key_x,
  input  logic [15:0] in_key_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_colour_position,
  output logic [7:0]  out_ring_alpha,
  output logic        out_alpha_applies,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int unsigned RoundW = $clog2(ROOT_ROUNDS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_TV, S_TVW, S_DX, S_DXW, S_DY, S_DYW, S_MIX,
    S_SQX, S_SQXW, S_SQY, S_SQYW, S_RDIV, S_RDIVW, S_RSTEP,
    S_CD, S_CDW, S_CT, S_CTW, S_RING, S_FMUL, S_FMULW, S_FDIV, S_FDIVW, S_OUT
  } state_t;

  state_t state_r;
  logic [31:0] flow_r, axis_r, cm_r, cs_r, ring_r;
  logic [31:0] ts_r, tval_r, dx_r, dy_r, dist_r, acc_r, guess_r, cpos_r;
  logic [15:0] kx_r, ky_r;
  logic [63:0] rnum_r;
  logic [RoundW-1:0] round_r;
  logic [7:0] alpha_r;
  logic [15:0] ocp_r;
  logic [7:0]  oal_r;
  logic        oap_r, ovalid_r;

  logic        mstart, mbusy, dstart, dbusy;
  logic [31:0] ma, mb, mprod, dquo, dden;
  logic [63:0] dnum;

  rfks_mul u_mul (.clk, .rst_n, .start(mstart), .a(ma), .b(mb),
                  .busy(mbusy), .prod(mprod));
  rfks_div u_div (.clk, .rst_n, .start(dstart), .num(dnum), .den(dden),
                  .busy(dbusy), .quo(dquo));

  // Field decodes of the configuration registers.
  logic [1:0]  method;
  logic [31:0] ring_point, ring_width, fade_span, off, mag, nextg, step;
  logic [15:0] dxo, dyo, dxm, dym;
  assign method     = cm_r[1:0];
  assign ring_point = {ring_r[31:16], 8'd0};
  assign ring_width = {12'd0, ring_r[15:8], 12'd0};
  assign fade_span  = {14'd0, ring_r[6:1], 12'd0};
  assign off  = dist_r + ring_point - tval_r;
  assign mag  = off[31] ? (32'd0 - off) : off;
  assign dxo  = kx_r - {cm_r[31:17], 1'b0};
  assign dyo  = ky_r - {cm_r[16:2], 1'b0};
  // The magnitude of -32768 wraps to 0x8000 in 16 bits, which is correct.
  assign dxm  = dxo[15] ? (16'd0 - dxo) : dxo;
  assign dym  = dyo[15] ? (16'd0 - dyo) : dyo;
  assign nextg = {1'b0, guess_r[31:1]} + dquo;
  assign step  = nextg - guess_r;

  always_comb begin
    mstart = 1'b0;
    dstart = 1'b0;
    ma = 32'd0;
    mb = 32'd0;
    dnum = 64'd0;
    dden = 32'd1;
    case (state_r)
      S_TV:   begin mstart = 1'b1; ma = ts_r; mb = flow_r; end
      S_DX:   begin mstart = 1'b1; ma = {16'd0, dxm}; mb = {8'd0, axis_r[31:16], 8'd0}; end
      S_DY:   begin mstart = 1'b1; ma = {16'd0, dym}; mb = {8'd0, axis_r[15:0], 8'd0}; end
      S_SQX:  begin mstart = 1'b1; ma = dx_r; mb = dx_r; end
      S_SQY:  begin mstart = 1'b1; ma = dy_r; mb = dy_r; end
      S_RDIV: begin dstart = 1'b1; dnum = rnum_r; dden = guess_r; end
      S_CD:   begin mstart = 1'b1; ma = dist_r; mb = {16'd0, cs_r[15:0]}; end
      S_CT:   begin mstart = 1'b1; ma = tval_r; mb = {16'd0, cs_r[31:16]}; end
      S_FMUL: begin mstart = 1'b1; ma = mag - ring_width; mb = 32'd255; end
      S_FDIV: begin dstart = 1'b1; dnum = {32'd0, acc_r}; dden = fade_span; end
      default: ;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      flow_r <= 32'd0; axis_r <= 32'd0; cm_r <= 32'd0; cs_r <= 32'd0; ring_r <= 32'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rfks_pkg::RegFlowSpeed:    flow_r <= cfg_data;
          rfks_pkg::RegAxisScales:   axis_r <= cfg_data;
          rfks_pkg::RegCentreMethod: cm_r   <= cfg_data;
          rfks_pkg::RegColourScales: cs_r   <= cfg_data;
          rfks_pkg::RegRingShape:    ring_r <= cfg_data;
          default: ;
        endcase
      end
      // A finished word enters the output register when it is empty or being taken.
      if (state_r == S_OUT && (!ovalid_r || !out_stall)) ovalid_r <= 1'b1;
      else if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid) begin
          ts_r <= in_time_stamp; kx_r <= in_key_x; ky_r <= in_key_y;
          state_r <= S_TV;
        end
        S_TV:  state_r <= S_TVW;
        S_TVW: if (!mbusy) begin tval_r <= {16'd0, mprod[31:16]}; state_r <= S_DX; end
        S_DX:  state_r <= S_DXW;
        S_DXW: if (!mbusy) begin dx_r <= {8'd0, mprod[31:8]}; state_r <= S_DY; end
        S_DY:  state_r <= S_DYW;
        S_DYW: if (!mbusy) begin dy_r <= {8'd0, mprod[31:8]}; state_r <= S_MIX; end
        S_MIX: begin
          case (method)
            rfks_pkg::MethodManhattan: begin dist_r <= dx_r + dy_r; state_r <= S_CD; end
            rfks_pkg::MethodMaximum: begin
              dist_r <= (dx_r > dy_r) ? dx_r : dy_r; state_r <= S_CD;
            end
            rfks_pkg::MethodRoot: state_r <= S_SQX;
            default: begin dist_r <= 32'd0; state_r <= S_CD; end
          endcase
        end
        S_SQX:  state_r <= S_SQXW;
        S_SQXW: if (!mbusy) begin acc_r <= {16'd0, mprod[31:16]}; state_r <= S_SQY; end
        S_SQY:  state_r <= S_SQYW;
        S_SQYW: if (!mbusy) begin
          // Sum of squares, then the root's first guess, raised to one if zero.
          rnum_r  <= {17'd0, acc_r + {16'd0, mprod[31:16]}, 15'd0};
          guess_r <= ((acc_r + {16'd0, mprod[31:16]}) >> 1) == 32'd0 ? 32'd1
                     : ((acc_r + {16'd0, mprod[31:16]}) >> 1);
          round_r <= '0;
          state_r <= S_RDIV;
        end
        S_RDIV:  state_r <= S_RDIVW;
        S_RDIVW: if (!dbusy) state_r <= S_RSTEP;
        S_RSTEP: begin
          dist_r <= nextg;
          if (step <= 32'd32766 || step >= 32'hFFFF8001 ||
              round_r == RoundW'(ROOT_ROUNDS - 1)) begin
            state_r <= S_CD;
          end else begin
            guess_r <= (nextg == 32'd0) ? 32'd1 : nextg;
            round_r <= round_r + RoundW'(1);
            state_r <= S_RDIV;
          end
        end
        S_CD:  state_r <= S_CDW;
        S_CDW: if (!mbusy) begin cpos_r <= {8'd0, mprod[31:8]}; state_r <= S_CT; end
        S_CT:  state_r <= S_CTW;
        S_CTW: if (!mbusy) begin
          cpos_r <= cpos_r + {8'd0, mprod[31:8]}; state_r <= S_RING;
        end
        S_RING: begin
          if (ring_width == 32'd0) begin
            alpha_r <= 8'd0; state_r <= S_OUT;
          end else if (mag <= ring_width) begin
            alpha_r <= 8'd255; state_r <= S_OUT;
          end else if (fade_span != 32'd0 && mag <= ring_width + fade_span) begin
            state_r <= S_FMUL;
          end else begin
            alpha_r <= 8'd0; state_r <= S_OUT;
          end
        end
        S_FMUL:  state_r <= S_FMULW;
        S_FMULW: if (!mbusy) begin acc_r <= mprod; state_r <= S_FDIV; end
        S_FDIV:  state_r <= S_FDIVW;
        S_FDIVW: if (!dbusy) begin alpha_r <= dquo[7:0]; state_r <= S_OUT; end
        S_OUT: if (!ovalid_r || !out_stall) begin
          // The output register frees the sequencer while the word waits.
          ocp_r <= cpos_r[15:0]; oal_r <= alpha_r; oap_r <= (ring_width != 32'd0);
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ovalid_r;
  assign out_colour_position = ocp_r;
  assign out_ring_alpha = oal_r;
  assign out_alpha_applies = oap_r;

  `RFKS_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, (state_r != S_IDLE) |-> in_stall)
  `RFKS_ASSERT_IMPL(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> out_valid)
  `RFKS_ASSERT_IMPL(a_units_excl, clk, rst_n, !(mbusy && dbusy))
  `RFKS_ASSERT_NORST(a_reset_idle, clk, !rst_n |=> !out_valid)
endmodule

@@ hw/rtl/rfks_mul.sv @@
// Shift-and-add multiplier, one multiplier bit per cycle, product mod 2^32.
module rfks_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        busy,
  output logic [31:0] prod
);
  logic [31:0] a_r, b_r, acc_r;
  logic [5:0]  cnt_r;
  logic        busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd0;
      a_r    <= a;
      b_r    <= b;
      acc_r  <= 32'd0;
    end else if (busy_r) begin
      if (b_r[0]) acc_r <= acc_r + a_r;
      a_r   <= {a_r[30:0], 1'b0};
      b_r   <= {1'b0, b_r[31:1]};
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd31) busy_r <= 1'b0;
    end
  end
  assign busy = busy_r;
  assign prod = acc_r;
endmodule

@@ hw/rtl/rfks_div.sv @@
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
// Only the low 32 quotient bits are kept.
module rfks_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        busy,
  output logic [31:0] quo
);
  logic [63:0] n_r;
  logic [32:0] rem_r;
  logic [31:0] d_r, q_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [32:0] trial;

  assign trial = {rem_r[31:0], n_r[63]} - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 7'd0;
      n_r    <= num;
      d_r    <= den;
      rem_r  <= 33'd0;
      q_r    <= 32'd0;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so 33 bits suffice.
      if (!trial[32]) rem_r <= trial;
      else rem_r <= {rem_r[31:0], n_r[63]};
      q_r   <= {q_r[30:0], ~trial[32]};
      n_r   <= {n_r[62:0], 1'b0};
      cnt_r <= cnt_r + 7'd1;
      if (cnt_r == 7'd63) busy_r <= 1'b0;
    end
  end
  assign busy = busy_r;
  assign quo  = q_r;
endmodule

@@ test/radial_flow_key_shader_core_tb.sv @@
module radial_flow_key_shader_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Rounds = 16;

  // Register images used by the shading predictor.
  logic [31:0] flow_speed_q, axis_scales_q, centre_q, colour_scales_q, ring_shape_q;

  typedef struct packed {
    logic [15:0] colour;
    logic [7:0]  alpha;
    logic        applies;
  } shade_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_time_stamp = '0;
  logic [15:0] in_key_x = '0;
  logic [15:0] in_key_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_colour_position;
  logic [7:0]  out_ring_alpha;
  logic        out_alpha_applies;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  shade_t shade_q[$];
  int     mismatches = 0;
  bit     quiet = 1'b0;

  radial_flow_key_shader_core #(.ROOT_ROUNDS(Rounds)) u_dut (.*);

  always #10 clk = ~clk;

  // Per-axis distance: wrapped signed offset magnitude times the 8.8 scale.
  function automatic logic [31:0] axis_dist(logic [15:0] pos, logic [15:0] ctr,
                                            logic [31:0] scale);
    logic [15:0] d;
    logic [31:0] mag;
    logic [31:0] prod;
    d = pos - ctr;
    mag = d[15] ? (32'h10000 - {16'h0, d}) : {16'h0, d};
    prod = scale * mag;
    return prod >> 8;
  endfunction

  // Newton iteration of sqrt(x) in 16.16, with zero guesses raised to one.
  function automatic logic [31:0] newton_root(logic [31:0] x);
    logic [63:0] num;
    logic [31:0] guess, nxt, step;
    logic [63:0] q;
    num = {32'h0, x} << 15;
    guess = x >> 1;
    nxt = '0;
    for (int r = 0; r < Rounds; r++) begin
      if (guess == 0) guess = 1;
      q = num / {32'h0, guess};
      nxt = (guess >> 1) + q[31:0];
      step = nxt - guess;
      if (step <= 32'd32766 || step >= 32'hFFFF8001) break;
      guess = nxt;
    end
    return nxt;
  endfunction

  function automatic shade_t shade_key(logic [31:0] ts, logic [15:0] kx, logic [15:0] ky);
    shade_t s;
    logic [31:0] tval, dx, dy, dist_v, sq, off, mag, rw, fw, rp, cpos, t32, a;
    logic [1:0]  method;
    t32 = ts * flow_speed_q;
    tval = t32 >> 16;
    dx = axis_dist(kx, {centre_q[31:17], 1'b0}, {8'h0, axis_scales_q[31:16], 8'h0});
    dy = axis_dist(ky, {centre_q[16:2], 1'b0}, {8'h0, axis_scales_q[15:0], 8'h0});
    method = centre_q[1:0];
    case (method)
      rfks_pkg::MethodManhattan: dist_v = dx + dy;
      rfks_pkg::MethodMaximum:   dist_v = (dx > dy) ? dx : dy;
      rfks_pkg::MethodRoot: begin
        sq = ((dx * dx) >> 16) + ((dy * dy) >> 16);
        dist_v = newton_root(sq);
      end
      default:                   dist_v = '0;
    endcase
    cpos = ((dist_v * {16'h0, colour_scales_q[15:0]}) >> 8)
         + ((tval * {16'h0, colour_scales_q[31:16]}) >> 8);
    rp = {8'h0, ring_shape_q[31:16], 8'h0};
    rw = {12'h0, ring_shape_q[15:8], 12'h0};
    fw = {14'h0, ring_shape_q[6:1], 12'h0};
    a = '0;
    if (rw != 0) begin
      off = dist_v + rp - tval;
      mag = off[31] ? (32'h0 - off) : off;
      if (mag <= rw) a = 32'd255;
      else if (fw != 0 && mag <= rw + fw) a = ((mag - rw) * 32'd255) / fw;
    end
    s.colour = cpos[15:0];
    s.alpha = a[7:0];
    s.applies = (rw != 0);
    return s;
  endfunction

  // Register writes happen only when nothing is in flight.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rfks_pkg::RegFlowSpeed:    flow_speed_q = val;
      rfks_pkg::RegAxisScales:   axis_scales_q = val;
      rfks_pkg::RegCentreMethod: centre_q = val;
      rfks_pkg::RegColourScales: colour_scales_q = val;
      default:                   ring_shape_q = val;
    endcase
  endtask

  task automatic drain();
    while (shade_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic configure(logic [31:0] fs, logic [31:0] ax, logic [31:0] cm,
                           logic [31:0] cs, logic [31:0] rs);
    drain();
    write_reg(rfks_pkg::RegFlowSpeed, fs);
    write_reg(rfks_pkg::RegAxisScales, ax);
    write_reg(rfks_pkg::RegCentreMethod, cm);
    write_reg(rfks_pkg::RegColourScales, cs);
    write_reg(rfks_pkg::RegRingShape, rs);
  endtask

  // Sends one word; the expectation is queued at the accepting edge.
  task automatic send_key(logic [31:0] ts, logic [15:0] kx, logic [15:0] ky);
    @(negedge clk);
    if (!quiet) while ($urandom_range(99) < 6) @(negedge clk);
    in_valid <= 1'b1;
    in_time_stamp <= ts;
    in_key_x <= kx;
    in_key_y <= ky;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shade_q.push_back(shade_key(ts, kx, ky));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  always @(negedge clk) out_stall <= !quiet && ($urandom_range(99) < 6);

  always @(posedge clk) begin
    shade_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_colour_position, out_ring_alpha, out_alpha_applies};
      if (shade_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        want = shade_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp colour %h alpha %h applies %b, got %h %h %b",
                     want.colour, want.alpha, want.applies,
                     got.colour, got.alpha, got.applies);
        end
      end
    end
  end

  function automatic logic [31:0] rnd_method_word();
    logic [31:0] w;
    w = $urandom();
    // Bias toward the root method, which has the most logic.
    if ($urandom_range(2) == 0) w[1:0] = rfks_pkg::MethodRoot;
    return w;
  endfunction

  task automatic test_reset_defaults();
    send_key(32'hFFFFFFFF, 16'hFFFF, 16'hFFFF);
    send_key(32'h0, 16'h0, 16'h0);
  endtask

  task automatic test_methods();
    for (int m = 0; m < 4; m++) begin
      configure(32'h00010000, 32'h01000100, {15'h0040, 15'h0040, m[1:0]},
                32'h01000100, 32'h1000_0406);
      send_key(32'h0, 16'h0, 16'h0);
      send_key(32'h1234, 16'hFFFF, 16'h0000);
      send_key(32'hFFFFFFFF, 16'h0080, 16'h8080);
      send_key(32'h10, 16'h4000, 16'h7FFF);
    end
  endtask

  task automatic test_extremes();
    configure(32'hFFFFFFFF, 32'hFFFFFFFF, {30'h3FFFFFFF, rfks_pkg::MethodRoot},
              32'hFFFFFFFF, 32'hFFFFFFFF);
    send_key(32'hFFFFFFFF, 16'h0000, 16'h0000);
    send_key(32'h80000000, 16'hFFFF, 16'h7FFE);
    // Ring width zero turns alpha off; fade width zero gives a hard edge.
    configure(32'h0, 32'h0, {30'h0, rfks_pkg::MethodMaximum}, 32'h0, 32'hFFFF00FF);
    send_key(32'h5, 16'h8000, 16'h8000);
    configure(32'h00008000, 32'h01000100, {30'h0, rfks_pkg::MethodManhattan}, 32'h00010001,
              32'h00000100);
    send_key(32'h1, 16'h0100, 16'h0000);
    send_key(32'h0, 16'h0000, 16'h0000);
  endtask

  task automatic test_random();
    for (int blk = 0; blk < 20; blk++) begin
      configure($urandom(), $urandom(), rnd_method_word(), $urandom(),
                $urandom_range(3) == 0 ? 32'h0 : $urandom());
      quiet = (blk == 7);
      for (int i = 0; i < 50; i++) begin
        send_key($urandom(), 16'($urandom()), 16'($urandom()));
        // In block 3, after word index 25, the sender holds off until every result is back.
        if (i == 25 && blk == 3) while (shade_q.size() != 0) @(negedge clk);
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    flow_speed_q = '0;
    axis_scales_q = '0;
    centre_q = '0;
    colour_scales_q = '0;
    ring_shape_q = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_methods();
    test_extremes();
    test_random();
    drain();
    repeat (400) @(negedge clk);
    if (mismatches == 0 && shade_q.size() == 0) $display("radial_flow_key_shader_core_tb OK");
    else $display("radial_flow_key_shader_core_tb NOT OK");
    $finish;
  end

  initial begin
    #300ms;
    $display("radial_flow_key_shader_core_tb NOT OK");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/rfks_pkg.sv
hw/rtl/rfks_mul.sv
hw/rtl/rfks_div.sv
hw/rtl/radial_flow_key_shader_core.sv
test/radial_flow_key_shader_core_tb.sv
